// ===== sv/triangle_walk_barycentric_locator_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the triangle walk locator
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_WALK_BARYCENTRIC_LOCATOR_ASSERT_SVH
`define TRIANGLE_WALK_BARYCENTRIC_LOCATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TWBL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TWBL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/twbl_pkg.sv =====
// ---------------------------------------------------------------------------
// twbl_pkg
// Shared widths, status codes, corner record and controller/datapath bundles.
// ---------------------------------------------------------------------------
package twbl_pkg;

    localparam int TRI_DEPTH = 64;
    localparam int TRI_AW    = 6;
    localparam int CNT_W     = 7;
    localparam int MAX_POSES = 32;
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int ACC_W     = 38;
    localparam int MAG_W     = 35;
    localparam int DEN_W     = 38;
    localparam int NUM_W     = MAG_W + 16 + 1;
    localparam int DVS_W     = DEN_W + 1;
    localparam int WQ_W      = NUM_W + 1;
    localparam int WC_W      = WQ_W + 2;
    localparam int OUT_W     = 17;
    localparam int ONE_Q15   = 32768;

    localparam logic [2:0] ST_INSIDE = 3'd0;
    localparam logic [2:0] ST_HULL   = 3'd1;
    localparam logic [2:0] ST_LIMIT  = 3'd2;
    localparam logic [2:0] ST_DEGEN  = 3'd3;
    localparam logic [2:0] ST_EMPTY  = 3'd4;
    localparam logic [2:0] ST_LOAD   = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [4:0]                pose;
        logic [6:0]                nb;
    } t_corner;

    typedef struct packed {
        logic       capture;
        logic       start_walk;
        logic       mac_go;
        logic [2:0] mac_step;
        logic       n2_go;
        logic       step_walk;
        logic       div_start;
        logic       div_sel;
        logic       div_clamp;
        logic       out_load;
        logic [2:0] out_status;
        logic       commit_last;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic empty;
        logic degen;
        logic in_tri;
        logic hull;
        logic div_done;
    } t_sts;

    function automatic logic signed [OUT_W-1:0] sat_w(input logic signed [WC_W-1:0] w);
        logic signed [OUT_W-1:0] res;
        if (w < -WC_W'(65536)) begin
            res = -OUT_W'(65536);
        end else if (w > WC_W'(65535)) begin
            res = OUT_W'(65535);
        end else begin
            res = w[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/twbl_div.sv =====
// ---------------------------------------------------------------------------
// twbl_div
// Restoring divider, one quotient bit per cycle. Gives the rounded quotient
// (2^16*mag + den) / (2*den), i.e. mag/den scaled by 2^15 and rounded half
// away from zero.
// ---------------------------------------------------------------------------
module twbl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [twbl_pkg::MAG_W-1:0]  i_mag,
    input  logic [twbl_pkg::DEN_W-1:0]  i_den,
    output logic [twbl_pkg::NUM_W-1:0]  o_q,
    output logic                        o_done
);
    import twbl_pkg::*;

    localparam int CW = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [NUM_W-1:0] r_q;
    logic [DVS_W:0]   w_rem_sh;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    assign w_rem_sh = {r_rem, r_num[NUM_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};
    assign w_ge     = w_rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NUM_W'({i_mag, 16'b0}) + NUM_W'(i_den);
            r_dvs <= {i_den, 1'b0};
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_rem_sh[DVS_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], w_ge};
        end
    end

    assign o_q    = r_q;
    assign o_done = r_done;

endmodule

// ===== sv/twbl_dp.sv =====
// ---------------------------------------------------------------------------
// twbl_dp
// Datapath: triangle table, shared multiply-accumulate for the barycentric
// numerators, walk decisions, divider and the result register.
// ---------------------------------------------------------------------------
module twbl_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  twbl_pkg::t_cmd                 i_cmd,
    output twbl_pkg::t_sts                 o_sts,
    input  logic                           i_cfg_we,
    input  logic [6:0]                     i_cfg_data,
    input  logic                           i_func,
    input  logic [5:0]                     i_entry,
    input  logic [1:0]                     i_corner,
    input  logic signed [15:0]             i_coord_x,
    input  logic signed [15:0]             i_coord_y,
    input  logic [4:0]                     i_pose,
    input  logic [6:0]                     i_neighbour,
    output logic [5:0]                     o_found_triangle,
    output logic [4:0]                     o_pose_a,
    output logic [4:0]                     o_pose_b,
    output logic [4:0]                     o_pose_c,
    output logic signed [16:0]             o_weight_a,
    output logic signed [16:0]             o_weight_b,
    output logic signed [16:0]             o_weight_c,
    output logic [2:0]                     o_status
);
    import twbl_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(TRI_DEPTH);
    localparam logic [5:0]       POSE_LIM = 6'(MAX_POSES);

    logic [CNT_W-1:0]          r_count;
    logic [TRI_AW-1:0]         r_last;
    logic                      r_func;
    logic [5:0]                r_entry;
    logic signed [COORD_W-1:0] r_qx;
    logic signed [COORD_W-1:0] r_qy;
    logic [TRI_AW-1:0]         r_cur;
    t_corner                   r_rd [3];
    t_corner                   w_wr;
    logic signed [PROD_W-1:0]  r_prod;
    logic [2:0]                r_acc_step;
    logic                      r_acc_go;
    logic signed [ACC_W-1:0]   r_d;
    logic signed [ACC_W-1:0]   r_n0;
    logic signed [ACC_W-1:0]   r_n1;
    logic signed [ACC_W-1:0]   r_n2;
    logic [NUM_W-1:0]          r_qa;
    logic [NUM_W-1:0]          r_qb;
    logic                      r_neg_a;
    logic                      r_neg_b;
    logic                      r_div_sel;

    logic [CNT_W-1:0]          w_count;
    logic [TRI_AW-1:0]         w_start;
    logic signed [DIFF_W-1:0]  w_y23, w_x13, w_x32, w_y13, w_qx3, w_qy3, w_y31;
    logic signed [DIFF_W-1:0]  w_op_a, w_op_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   w_pext;
    logic [1:0]                w_k;
    logic [6:0]                w_nxt;
    logic signed [ACC_W-1:0]   w_c0, w_c1, w_c2, w_sum;
    logic signed [ACC_W-1:0]   w_nsel, w_ncl, w_nabs;
    logic [DEN_W-1:0]          w_den;
    logic [NUM_W-1:0]          w_q;
    logic                      w_div_done;
    logic signed [WQ_W-1:0]    w_wa, w_wb;
    logic signed [WC_W-1:0]    w_wc;

    // Configuration and last found triangle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_last  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (i_cmd.commit_last) begin
                r_last <= r_cur;
            end
        end
    end

    assign w_count = (r_count > CNT_MAX) ? CNT_MAX : r_count;
    assign w_start = ({1'b0, r_last} < w_count) ? r_last : '0;

    // Captured transaction fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_func;
            r_entry <= i_entry;
            r_qx    <= i_coord_x;
            r_qy    <= i_coord_y;
        end
    end

    // One table per corner; each written at one address and read at r_cur.
    // A 6-bit entry always lies inside the 64-deep table.
    always_comb begin
        w_wr.x    = i_coord_x;
        w_wr.y    = i_coord_y;
        w_wr.pose = ({1'b0, i_pose} >= POSE_LIM) ? 5'(MAX_POSES - 1) : i_pose;
        w_wr.nb   = i_neighbour;
    end

    for (genvar g = 0; g < 3; g++) begin : g_corner
        t_corner mem [TRI_DEPTH];
        always_ff @(posedge i_clk) begin
            if (i_cmd.capture && !i_func && (i_corner == 2'(g))) begin
                mem[i_entry] <= w_wr;
            end
            r_rd[g] <= mem[r_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_walk) begin
            r_cur <= w_start;
        end else if (i_cmd.step_walk) begin
            r_cur <= w_nxt[TRI_AW-1:0];
        end
    end

    // Vertex differences, sign-extended to 17 bits
    assign w_y23 = DIFF_W'(r_rd[1].y) - DIFF_W'(r_rd[2].y);
    assign w_x13 = DIFF_W'(r_rd[0].x) - DIFF_W'(r_rd[2].x);
    assign w_x32 = DIFF_W'(r_rd[2].x) - DIFF_W'(r_rd[1].x);
    assign w_y13 = DIFF_W'(r_rd[0].y) - DIFF_W'(r_rd[2].y);
    assign w_y31 = DIFF_W'(r_rd[2].y) - DIFF_W'(r_rd[0].y);
    assign w_qx3 = DIFF_W'(r_qx) - DIFF_W'(r_rd[2].x);
    assign w_qy3 = DIFF_W'(r_qy) - DIFF_W'(r_rd[2].y);

    always_comb begin
        case (i_cmd.mac_step)
            3'd0: begin w_op_a = w_y23; w_op_b = w_x13; end
            3'd1: begin w_op_a = w_x32; w_op_b = w_y13; end
            3'd2: begin w_op_a = w_y23; w_op_b = w_qx3; end
            3'd3: begin w_op_a = w_x32; w_op_b = w_qy3; end
            3'd4: begin w_op_a = w_y31; w_op_b = w_qx3; end
            3'd5: begin w_op_a = w_x13; w_op_b = w_qy3; end
            default: begin w_op_a = '0; w_op_b = '0; end
        endcase
    end

    assign w_prod = PROD_W'(w_op_a) * PROD_W'(w_op_b);
    assign w_pext = ACC_W'(r_prod);

    // Even steps start a sum, odd steps add the second product to it.
    always_ff @(posedge i_clk) begin
        r_acc_go   <= i_cmd.mac_go;
        r_acc_step <= i_cmd.mac_step;
        if (i_cmd.mac_go) begin
            r_prod <= w_prod;
        end
        if (r_acc_go) begin
            case (r_acc_step[2:1])
                2'd0:    r_d  <= r_acc_step[0] ? r_d + w_pext : w_pext;
                2'd1:    r_n0 <= r_acc_step[0] ? r_n0 + w_pext : w_pext;
                default: r_n1 <= r_acc_step[0] ? r_n1 + w_pext : w_pext;
            endcase
        end
        if (i_cmd.n2_go) begin
            r_n2 <= r_d - r_n0 - r_n1;
        end
    end

    // Smallest numerator picks the edge; ties go to the later corner.
    always_comb begin
        if (r_n0 < r_n1) begin
            w_k = (r_n0 < r_n2) ? 2'd0 : 2'd2;
        end else begin
            w_k = (r_n1 < r_n2) ? 2'd1 : 2'd2;
        end
    end

    assign w_nxt = r_rd[w_k].nb;

    // Divider operands: at the hull edge the numerators are clamped at zero
    // and normalised by their sum instead of the denominator.
    assign w_c0   = r_n0[ACC_W-1] ? '0 : r_n0;
    assign w_c1   = r_n1[ACC_W-1] ? '0 : r_n1;
    assign w_c2   = r_n2[ACC_W-1] ? '0 : r_n2;
    assign w_sum  = w_c0 + w_c1 + w_c2;
    assign w_nsel = i_cmd.div_sel ? r_n1 : r_n0;
    assign w_ncl  = (i_cmd.div_clamp && w_nsel[ACC_W-1]) ? '0 : w_nsel;
    assign w_nabs = w_ncl[ACC_W-1] ? -w_ncl : w_ncl;
    assign w_den  = i_cmd.div_clamp ? DEN_W'(w_sum) : DEN_W'(r_d);

    twbl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_mag   (w_nabs[MAG_W-1:0]),
        .i_den   (w_den),
        .o_q     (w_q),
        .o_done  (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
            if (i_cmd.div_sel) begin
                r_neg_b <= w_ncl[ACC_W-1];
            end else begin
                r_neg_a <= w_ncl[ACC_W-1];
            end
        end
        if (w_div_done) begin
            if (r_div_sel) begin
                r_qb <= w_q;
            end else begin
                r_qa <= w_q;
            end
        end
    end

    assign w_wa = r_neg_a ? -$signed({1'b0, r_qa}) : $signed({1'b0, r_qa});
    assign w_wb = r_neg_b ? -$signed({1'b0, r_qb}) : $signed({1'b0, r_qb});
    assign w_wc = WC_W'(ONE_Q15) - WC_W'(w_wa) - WC_W'(w_wb);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status <= i_cmd.out_status;
            case (i_cmd.out_status)
                ST_LOAD: begin
                    o_found_triangle <= r_entry;
                    o_pose_a   <= '0;
                    o_pose_b   <= '0;
                    o_pose_c   <= '0;
                    o_weight_a <= '0;
                    o_weight_b <= '0;
                    o_weight_c <= '0;
                end
                ST_EMPTY: begin
                    o_found_triangle <= '0;
                    o_pose_a   <= '0;
                    o_pose_b   <= '0;
                    o_pose_c   <= '0;
                    o_weight_a <= OUT_W'(ONE_Q15);
                    o_weight_b <= '0;
                    o_weight_c <= '0;
                end
                ST_DEGEN: begin
                    o_found_triangle <= r_cur;
                    o_pose_a   <= r_rd[0].pose;
                    o_pose_b   <= r_rd[1].pose;
                    o_pose_c   <= r_rd[2].pose;
                    o_weight_a <= '0;
                    o_weight_b <= '0;
                    o_weight_c <= '0;
                end
                default: begin
                    o_found_triangle <= r_cur;
                    o_pose_a   <= r_rd[0].pose;
                    o_pose_b   <= r_rd[1].pose;
                    o_pose_c   <= r_rd[2].pose;
                    o_weight_a <= sat_w(WC_W'(w_wa));
                    o_weight_b <= sat_w(WC_W'(w_wb));
                    o_weight_c <= sat_w(w_wc);
                end
            endcase
        end
    end

    always_comb begin
        o_sts.func     = r_func;
        o_sts.empty    = (w_count == '0);
        o_sts.degen    = r_d[ACC_W-1] || (r_d == '0);
        o_sts.in_tri   = !r_n0[ACC_W-1] && !r_n1[ACC_W-1] && !r_n2[ACC_W-1];
        o_sts.hull     = w_nxt >= w_count;
        o_sts.div_done = w_div_done;
    end

endmodule

// ===== sv/twbl_ctrl.sv =====
// ---------------------------------------------------------------------------
// twbl_ctrl
// Sequencer for the walk: dispatch, table read, numerator build, decision,
// two divisions and the hand-over to the result register.
// ---------------------------------------------------------------------------
`include "triangle_walk_barycentric_locator_assert.svh"

module twbl_ctrl #(
    parameter int MAX_STEPS = 100
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output twbl_pkg::t_cmd o_cmd,
    input  twbl_pkg::t_sts i_sts
);
    import twbl_pkg::*;

    localparam int          EW        = $clog2(MAX_STEPS + 1);
    localparam logic [EW-1:0] EVAL_LAST = EW'(MAX_STEPS - 1);
    localparam logic [2:0]  MAC_LAST  = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_READ, S_MAC, S_N2, S_EVAL,
        S_DIV_A, S_WAIT_A, S_DIV_B, S_WAIT_B, S_FINISH
    } t_state;

    t_state        r_state;
    logic          r_out_valid;
    logic [2:0]    r_step;
    logic [EW-1:0] r_evals;
    logic [2:0]    r_status;
    logic          w_ready;
    logic          w_accept;
    logic          w_slot_free;
    logic          w_limit;
    logic          w_degen_stop;

    // Nothing is taken while reset is held.
    assign w_ready      = (r_state == S_IDLE) && i_rst_n;
    assign w_accept     = w_ready && i_in_valid;
    assign w_slot_free  = !r_out_valid || i_out_ready;
    assign w_limit      = (r_evals == EVAL_LAST);
    assign w_degen_stop = (r_state == S_EVAL) && i_sts.degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_evals     <= '0;
            r_status    <= ST_INSIDE;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) r_state <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    r_evals <= '0;
                    if (!i_sts.func) begin
                        r_status <= ST_LOAD;
                        r_state  <= S_FINISH;
                    end else if (i_sts.empty) begin
                        r_status <= ST_EMPTY;
                        r_state  <= S_FINISH;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_step  <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (r_step == MAC_LAST) begin
                        r_state <= S_N2;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_N2: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (i_sts.degen) begin
                        r_status <= ST_DEGEN;
                        r_state  <= S_FINISH;
                    end else if (i_sts.in_tri) begin
                        r_status <= ST_INSIDE;
                        r_state  <= S_DIV_A;
                    end else if (i_sts.hull) begin
                        r_status <= ST_HULL;
                        r_state  <= S_DIV_A;
                    end else if (w_limit) begin
                        r_status <= ST_LIMIT;
                        r_state  <= S_DIV_A;
                    end else begin
                        r_evals <= r_evals + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_DIV_A: r_state <= S_WAIT_A;
                S_WAIT_A: begin
                    if (i_sts.div_done) r_state <= S_DIV_B;
                end
                S_DIV_B: r_state <= S_WAIT_B;
                S_WAIT_B: begin
                    if (i_sts.div_done) r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.capture     = w_accept;
        o_cmd.start_walk  = (r_state == S_DISPATCH) && i_sts.func && !i_sts.empty;
        o_cmd.mac_go      = (r_state == S_MAC) && (r_step != MAC_LAST);
        o_cmd.mac_step    = r_step;
        o_cmd.n2_go       = (r_state == S_N2);
        o_cmd.step_walk   = (r_state == S_EVAL) && !i_sts.degen && !i_sts.in_tri
                            && !i_sts.hull && !w_limit;
        o_cmd.div_start   = (r_state == S_DIV_A) || (r_state == S_DIV_B);
        o_cmd.div_sel     = (r_state == S_DIV_B);
        o_cmd.div_clamp   = (r_status == ST_HULL);
        o_cmd.out_load    = (r_state == S_FINISH) && w_slot_free;
        o_cmd.out_status  = r_status;
        o_cmd.commit_last = o_cmd.out_load && !(r_status inside {ST_LOAD, ST_EMPTY});
    end

    assign o_in_ready  = w_ready;
    assign o_out_valid = r_out_valid;

    `TWBL_ASSERT_NEXT(a_accept_dispatch, w_accept, r_state == S_DISPATCH, "not dispatched")
    `TWBL_ASSERT_NEXT(a_degen_stops, w_degen_stop, r_status == ST_DEGEN, "degenerate walk ran on")
    `TWBL_ASSERT_NEXT(a_div_b_finish, (r_state == S_WAIT_B) && i_sts.div_done, r_state == S_FINISH, "no result")
    `TWBL_ASSERT_NOW(a_evals_bound, 1'b1, r_evals <= EVAL_LAST, "walk step count beyond the limit")

endmodule

// ===== sv/triangle_walk_barycentric_locator.sv =====
// ---------------------------------------------------------------------------
// triangle_walk_barycentric_locator
// A load or an empty table goes from dispatch straight to the finish state; a
// locate reads the table, forms six products, the third numerator and the
// walk decision for each triangle visited, then runs two bit-serial divisions
// (a degenerate stop skips the divisions). One transaction at a time; the next
// is taken while a result waits. Reset (synchronous, active low) clears the
// count register and the last triangle; the triangle table is not cleared.
// ---------------------------------------------------------------------------
module triangle_walk_barycentric_locator #(
    parameter int MAX_STEPS = 100
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic [5:0]         i_entry,
    input  logic [1:0]         i_corner,
    input  logic signed [15:0] i_coord_x,
    input  logic signed [15:0] i_coord_y,
    input  logic [4:0]         i_pose,
    input  logic [6:0]         i_neighbour,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [5:0]         o_found_triangle,
    output logic [4:0]         o_pose_a,
    output logic [4:0]         o_pose_b,
    output logic [4:0]         o_pose_c,
    output logic signed [16:0] o_weight_a,
    output logic signed [16:0] o_weight_b,
    output logic signed [16:0] o_weight_c,
    output logic [2:0]         o_status
);
    import twbl_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    twbl_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    twbl_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_func           (i_func),
        .i_entry          (i_entry),
        .i_corner         (i_corner),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_pose           (i_pose),
        .i_neighbour      (i_neighbour),
        .o_found_triangle (o_found_triangle),
        .o_pose_a         (o_pose_a),
        .o_pose_b         (o_pose_b),
        .o_pose_c         (o_pose_c),
        .o_weight_a       (o_weight_a),
        .o_weight_b       (o_weight_b),
        .o_weight_c       (o_weight_c),
        .o_status         (o_status)
    );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Triangle walk locator testbench
// Loads a regular triangulated grid, or hand-made broken meshes, and sends
// locate queries through the block. A behavioural predictor walks the same
// table and gives the expected triangle, poses, weights and status for each
// transaction. Both handshakes idle at random.
// ---------------------------------------------------------------------------
module testbench;
    import twbl_pkg::*;

    localparam logic       FUNC_LOAD    = 1'b0;
    localparam logic       FUNC_LOCATE  = 1'b1;
    localparam logic [6:0] NO_NEIGHBOUR = 7'd64;
    localparam int         WALK_LIMIT   = 100;
    localparam int         STALL_LIMIT  = 20000;

    typedef struct {
        logic [5:0]         tri_idx;
        logic [4:0]         pose_a, pose_b, pose_c;
        logic signed [16:0] weight_a, weight_b, weight_c;
        logic [2:0]         status;
    } t_locate_result;

    logic               i_clk, i_rst_n, i_cfg_we, i_in_valid, i_out_ready;
    logic [6:0]         i_cfg_data;
    logic               o_in_ready, o_out_valid;
    logic               i_func;
    logic [5:0]         i_entry;
    logic [1:0]         i_corner;
    logic signed [15:0] i_coord_x, i_coord_y;
    logic [4:0]         i_pose;
    logic [6:0]         i_neighbour;
    logic [5:0]         o_found_triangle;
    logic [4:0]         o_pose_a, o_pose_b, o_pose_c;
    logic signed [16:0] o_weight_a, o_weight_b, o_weight_c;
    logic [2:0]         o_status;

    // Predictor copy of the triangle table and registers.
    logic signed [15:0] mesh_x[64][3];
    logic signed [15:0] mesh_y[64][3];
    logic [4:0]         mesh_pose[64][3];
    logic [6:0]         mesh_nb[64][3];
    logic [5:0]         walk_start;
    logic [6:0]         tri_count;

    t_locate_result pending_results[$];
    int  error_count;
    int  status_seen[8];
    int  stall_cycles;
    bit  idle_on;

    triangle_walk_barycentric_locator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_func(i_func), .i_entry(i_entry), .i_corner(i_corner),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .i_pose(i_pose), .i_neighbour(i_neighbour),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_found_triangle(o_found_triangle),
        .o_pose_a(o_pose_a), .o_pose_b(o_pose_b), .o_pose_c(o_pose_c),
        .o_weight_a(o_weight_a), .o_weight_b(o_weight_b), .o_weight_c(o_weight_c),
        .o_status(o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag * 2 + den) / (den * 2);
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [16:0] clip_weight(longint w);
        if (w < -65536) w = -65536;
        if (w > 65535) w = 65535;
        return w[16:0];
    endfunction

    function automatic int smallest_corner(longint a, longint b, longint c);
        return (a < b) ? ((a < c) ? 0 : 2) : ((b < c) ? 1 : 2);
    endfunction

    // Applies one transaction to the predictor state and returns its result.
    function automatic t_locate_result predict_locate(logic func, logic [5:0] entry,
            logic [1:0] corner, logic signed [15:0] qx, logic signed [15:0] qy,
            logic [4:0] pose, logic [6:0] nb);
        t_locate_result res;
        int      active, cur, evals, k;
        logic [2:0] st;
        longint  x1, y1, x2, y2, x3, y3, px, py, den, s;
        longint  n[3];
        longint  wa, wb, wc;
        res = '{default: 0};
        wa = 0; wb = 0; wc = 0;
        n[0] = 0; n[1] = 0; n[2] = 0; den = 0;
        if (func == FUNC_LOAD) begin
            if (corner != 2'd3) begin
                mesh_x[entry][corner]    = qx;
                mesh_y[entry][corner]    = qy;
                mesh_pose[entry][corner] = pose;
                mesh_nb[entry][corner]   = nb;
            end
            res.tri_idx = entry;
            res.status  = ST_LOAD;
            return res;
        end
        active = (tri_count > 64) ? 64 : tri_count;
        if (active == 0) begin
            res.weight_a = 17'sd32768;
            res.status   = ST_EMPTY;
            return res;
        end
        px = qx; py = qy;
        cur = (walk_start < active) ? walk_start : 0;
        evals = 0;
        forever begin
            x1 = mesh_x[cur][0]; y1 = mesh_y[cur][0];
            x2 = mesh_x[cur][1]; y2 = mesh_y[cur][1];
            x3 = mesh_x[cur][2]; y3 = mesh_y[cur][2];
            den = (y2 - y3) * (x1 - x3) + (x3 - x2) * (y1 - y3);
            evals++;
            if (den <= 0) begin st = ST_DEGEN; break; end
            n[0] = (y2 - y3) * (px - x3) + (x3 - x2) * (py - y3);
            n[1] = (y3 - y1) * (px - x3) + (x1 - x3) * (py - y3);
            n[2] = den - n[0] - n[1];
            if (n[0] >= 0 && n[1] >= 0 && n[2] >= 0) begin st = ST_INSIDE; break; end
            k = smallest_corner(n[0], n[1], n[2]);
            if (mesh_nb[cur][k] >= active) begin st = ST_HULL; break; end
            if (evals >= WALK_LIMIT) begin st = ST_LIMIT; break; end
            cur = mesh_nb[cur][k];
        end
        if (st == ST_INSIDE || st == ST_LIMIT) begin
            wa = round_div(n[0] * 32768, den);
            wb = round_div(n[1] * 32768, den);
            wc = 32768 - wa - wb;
        end else if (st == ST_HULL) begin
            for (int i = 0; i < 3; i++) if (n[i] < 0) n[i] = 0;
            s  = n[0] + n[1] + n[2];
            wa = round_div(n[0] * 32768, s);
            wb = round_div(n[1] * 32768, s);
            wc = 32768 - wa - wb;
        end
        walk_start   = cur;
        res.tri_idx  = cur;
        res.pose_a   = mesh_pose[cur][0];
        res.pose_b   = mesh_pose[cur][1];
        res.pose_c   = mesh_pose[cur][2];
        res.weight_a = clip_weight(wa);
        res.weight_b = clip_weight(wb);
        res.weight_c = clip_weight(wc);
        res.status   = st;
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        error_count++;
        $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    endtask

    task automatic send_item(logic func, logic [5:0] entry, logic [1:0] corner,
            int qx, int qy, logic [4:0] pose, logic [6:0] nb);
        t_locate_result exp_res;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 99) < 30) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_func = func; i_entry = entry; i_corner = corner;
        i_coord_x = 16'(qx); i_coord_y = 16'(qy);
        i_pose = pose; i_neighbour = nb;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        exp_res = predict_locate(func, entry, corner, 16'(qx), 16'(qy), pose, nb);
        pending_results.insert(pending_results.size(), exp_res);
    endtask

    task automatic locate(int qx, int qy);
        send_item(FUNC_LOCATE, 6'($urandom), 2'($urandom), qx, qy, 5'($urandom),
                  7'($urandom));
    endtask

    // Register writes happen only once the block has drained.
    task automatic write_count(logic [6:0] value);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        tri_count = value;
    endtask

    // Grid of 8 by 4 squares, each split into a lower and an upper triangle.
    task automatic load_grid(int step, int ox, int oy);
        int base, gx[3], gy[3], gn[3];
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 8; c++) begin
                base = 2 * (r * 8 + c);
                gx = '{c, c + 1, c + 1}; gy = '{r, r, r + 1};
                gn[0] = (c < 7) ? base + 3 : NO_NEIGHBOUR;
                gn[1] = base + 1;
                gn[2] = (r > 0) ? base - 15 : NO_NEIGHBOUR;
                for (int k = 0; k < 3; k++)
                    send_item(FUNC_LOAD, 6'(base), 2'(k), ox + gx[k] * step,
                              oy + gy[k] * step, 5'($urandom), 7'(gn[k]));
                gx = '{c, c + 1, c}; gy = '{r, r + 1, r + 1};
                gn[0] = (r < 3) ? base + 16 : NO_NEIGHBOUR;
                gn[1] = (c > 0) ? base - 2 : NO_NEIGHBOUR;
                gn[2] = base;
                for (int k = 0; k < 3; k++)
                    send_item(FUNC_LOAD, 6'(base + 1), 2'(k), ox + gx[k] * step,
                              oy + gy[k] * step, 5'($urandom), 7'(gn[k]));
            end
        end
    endtask

    task automatic load_random_grid(output int step, output int ox, output int oy);
        step = $urandom_range(64, 3000);
        ox = $urandom_range(0, 65535 - 8 * step) - 32768;
        oy = $urandom_range(0, 65535 - 4 * step) - 32768;
        load_grid(step, ox, oy);
    endtask

    task automatic test_empty_table();
        locate(-32768, 32767);
        locate(32767, -32768);
        send_item(FUNC_LOAD, 6'd63, 2'd3, 32767, -32768, 5'd31, 7'd127);
        locate(0, 0);
    endtask

    task automatic test_grid_walk();
        load_grid(256, -1024, -512);
        write_count(7'd64);
        locate(-1024 + 7 * 256 + 200, -512 + 3 * 256 + 30);
        locate(-1024 + 100, -512 + 50);
        locate(-1024, -512);
        locate(-1024 + 128, -512 + 128);
        locate(32767, 32767);
        locate(-32768, -32768);
        write_count(7'd127);
        locate(-1024 + 700, -512 + 900);
        write_count(7'd4);
        locate(-1024 + 50, -512 + 10);
        write_count(7'd1);
        locate(-1024 + 2000, -512 + 10);
    endtask

    task automatic test_broken_mesh();
        for (int k = 0; k < 3; k++)
            send_item(FUNC_LOAD, 6'd0, 2'(k), 100 * k, 100 * k, 5'(k), 7'd1);
        locate(5, 5);
        send_item(FUNC_LOAD, 6'd0, 2'd0, 0, 0, 5'd1, 7'd1);
        send_item(FUNC_LOAD, 6'd0, 2'd1, 256, 0, 5'd2, 7'd1);
        send_item(FUNC_LOAD, 6'd0, 2'd2, 0, 256, 5'd3, 7'd1);
        send_item(FUNC_LOAD, 6'd1, 2'd0, 1000, 1000, 5'd4, 7'd0);
        send_item(FUNC_LOAD, 6'd1, 2'd1, 1256, 1000, 5'd5, 7'd0);
        send_item(FUNC_LOAD, 6'd1, 2'd2, 1000, 1256, 5'd6, 7'd0);
        write_count(7'd2);
        locate(-30000, 30000);
        locate(20, 20);
    endtask

    task automatic test_random_walks();
        int step, ox, oy;
        logic [6:0] counts[7];
        counts = '{7'd64, 7'd0, 7'd1, 7'd64, 7'd127, 7'd64, 7'd64};
        for (int ph = 0; ph < 7; ph++) begin
            idle_on = (ph != 2);
            if (ph == 0) load_random_grid(step, ox, oy);
            if (ph == 5) write_count(7'($urandom_range(2, 63)));
            else if (ph == 6) write_count(7'($urandom_range(65, 126)));
            else write_count(counts[ph]);
            for (int i = 0; i < 42; i++) begin
                if ($urandom_range(0, 99) < 20)
                    send_item(FUNC_LOAD, 6'($urandom), 2'($urandom), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), 5'($urandom), 7'($urandom));
                else if ($urandom_range(0, 99) < 85)
                    locate(ox + $urandom_range(0, 8 * step), oy + $urandom_range(0, 4 * step));
                else
                    locate($urandom_range(0, 65535), $urandom_range(0, 65535));
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = !idle_on || ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge i_clk) begin
        t_locate_result want;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", pending_results.size());
            $display("Some tests failed");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", o_status, -1);
            end else begin
                want = pending_results.pop_front();
                status_seen[want.status]++;
                if (o_found_triangle !== want.tri_idx)
                    report_mismatch("found_triangle", o_found_triangle, want.tri_idx);
                if (o_pose_a !== want.pose_a) report_mismatch("pose_a", o_pose_a, want.pose_a);
                if (o_pose_b !== want.pose_b) report_mismatch("pose_b", o_pose_b, want.pose_b);
                if (o_pose_c !== want.pose_c) report_mismatch("pose_c", o_pose_c, want.pose_c);
                if (o_weight_a !== want.weight_a)
                    report_mismatch("weight_a", o_weight_a, want.weight_a);
                if (o_weight_b !== want.weight_b)
                    report_mismatch("weight_b", o_weight_b, want.weight_b);
                if (o_weight_c !== want.weight_c)
                    report_mismatch("weight_c", o_weight_c, want.weight_c);
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
            end
        end
    end

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_data = '0; i_in_valid = 1'b0;
        i_func = FUNC_LOAD; i_entry = '0; i_corner = '0; i_coord_x = '0; i_coord_y = '0;
        i_pose = '0; i_neighbour = '0;
        error_count = 0; stall_cycles = 0; idle_on = 1'b1;
        walk_start = '0; tri_count = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_grid_walk();
        test_broken_mesh();
        test_random_walks();

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Results checked: %0d inside, %0d hull, %0d step limit, %0d degenerate,",
                 status_seen[ST_INSIDE], status_seen[ST_HULL], status_seen[ST_LIMIT],
                 status_seen[ST_DEGEN]);
        $display("%0d empty table and %0d loads; %0d mismatches.",
                 status_seen[ST_EMPTY], status_seen[ST_LOAD], error_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== triangle_walk_barycentric_locator.f =====
+incdir+sv
sv/twbl_pkg.sv
sv/twbl_div.sv
sv/twbl_dp.sv
sv/twbl_ctrl.sv
sv/triangle_walk_barycentric_locator.sv
tb/sv/testbench.sv
